// ----- rtl/rdc_pkg.sv -----
// Package for the radix digit converter: shared constants, the controller
// state type and the command and status structs between controller and datapath.
// No dependencies.
package rdc_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int STEP_BITS      = 8;
  localparam int RADIX_W        = 5;
  localparam int DIGIT_W        = 4;
  localparam int OUT_DATA_W     = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH,
    ST_POP
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic push;
    logic pop;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic q_zero;
    logic cnt_zero;
    logic cnt_one;
    logic pop_ready;
  } dp_status_t;

endpackage

// ----- rtl/radix_digit_converter.sv -----
// Radix digit converter top level: joins the controller and the datapath.
// Depends on rdc_pkg, rdc_ctrl, rdc_datapath and rdc_ram.
// Usage:
//   cfg_*  : write the radix (2..16; smaller values act as 2, larger as 16).
//            Always ready. Write only while the block is idle.
//   in_*   : one item is one non-negative value in the low VALUE_BITS of
//            in_tdata. in_tready is high only while no conversion runs.
//   out_*  : one item per digit, most significant first, digit in
//            out_tdata[3:0], out_tlast high on the least significant digit.
//            A value of zero gives the single digit 0.
// Sequence: for each digit the divider works through CHUNKS chunks, with
//   CHUNKS = ceil(VALUE_BITS / 8) (the divider retires 8 quotient bits per
//   cycle), and then pushes the digit onto the stack RAM; once the quotient
//   is zero the digits are popped from the stack RAM. The next item is taken
//   once the last digit has left the stack.
// Reset (rst_n low, synchronous): radix returns to 10, the controller goes
//   idle and out_tvalid drops. The digit stack is not cleared.
// Stall: while out_tready is low the output register holds its item and the
//   stack pops pause.
module radix_digit_converter
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [RADIX_W-1:0]              cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0] in_tdata,   // [VALUE_BITS-1:0] value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_DATA_W-1:0]           out_tdata,  // [3:0] digit
  output logic                            out_tlast
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rdc_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

// ----- rtl/rdc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/rdc_datapath.sv -----
// Datapath of the radix digit converter: radix register, chunked divider,
// digit stack (rdc_ram) and output register. Depends on rdc_pkg and rdc_ram.
module rdc_datapath
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [RADIX_W-1:0]                   cfg_data,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]      in_tdata,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic [OUT_DATA_W-1:0]                out_tdata,
  output logic                                 out_tlast,
  input  dp_cmd_t                              cmd,
  output dp_status_t                           status
);

  localparam int CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD    = CHUNKS * STEP_BITS;
  localparam int CHW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CW     = $clog2(VALUE_BITS + 1);
  localparam int AW     = $clog2(VALUE_BITS);
  localparam logic [CHW-1:0] CHUNK_TOP = CHW'(CHUNKS - 1);

  logic [RADIX_W-1:0] radix_r;
  logic [PAD-1:0]     q_r, q_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [CHW-1:0]     chunk_r;
  logic [CW-1:0]      cnt_r;
  logic               rd_pend_r;
  logic               rd_last_r;
  logic               out_valid_r;
  logic [DIGIT_W-1:0] out_digit_r;
  logic               out_last_r;
  logic               out_load;
  logic [DIGIT_W-1:0] rd_data;
  logic [CW-1:0]      cnt_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_valid) begin
      if (cfg_data < RADIX_MIN) begin
        radix_r <= RADIX_MIN;
      end else if (cfg_data > RADIX_MAX) begin
        radix_r <= RADIX_MAX;
      end else begin
        radix_r <= cfg_data;
      end
    end
  end

  // Long division of the top chunk, one bit per inner step.
  always_comb begin
    logic [RADIX_W-1:0]   t;
    logic [DIGIT_W-1:0]   r;
    logic [STEP_BITS-1:0] qb;
    logic [PAD-1:0]       sh;
    r  = rem_r;
    qb = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      t = {r, q_r[PAD-STEP_BITS+i]};
      if (t >= radix_r) begin
        qb[i] = 1'b1;
        t     = t - radix_r;
      end
      r = t[DIGIT_W-1:0];
    end
    sh                  = q_r << STEP_BITS;
    sh[STEP_BITS-1:0]   = qb;
    q_nxt               = sh;
    rem_nxt             = r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r <= {{(PAD-VALUE_BITS){1'b0}}, in_tdata[VALUE_BITS-1:0]};
    end else if (cmd.div_step) begin
      q_r <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      chunk_r <= '0;
    end else if (cmd.load || cmd.div_init) begin
      rem_r   <= '0;
      chunk_r <= CHUNK_TOP;
    end else if (cmd.div_step) begin
      rem_r   <= rem_nxt;
      chunk_r <= chunk_r - 1'b1;
    end
  end

  assign cnt_dec = cnt_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.push) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.pop) begin
      cnt_r <= cnt_dec;
    end
  end

  rdc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_stack (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (rem_r),
    .rd_en   (cmd.pop),
    .rd_addr (cnt_dec[AW-1:0]),
    .rd_data (rd_data)
  );

  assign out_load = rd_pend_r && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else if (cmd.pop) begin
      rd_pend_r <= 1'b1;
    end else if (out_load) begin
      rd_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      rd_last_r <= (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_digit_r <= rd_data;
      out_last_r  <= rd_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-DIGIT_W){1'b0}}, out_digit_r};
  assign out_tlast  = out_last_r;

  assign status.div_last  = (chunk_r == '0);
  assign status.q_zero    = (q_r == '0);
  assign status.cnt_zero  = (cnt_r == '0);
  assign status.cnt_one   = (cnt_r == CW'(1));
  assign status.pop_ready = !rd_pend_r || out_load;

endmodule

// ----- rtl/rdc_ctrl.sv -----
// Controller state machine of the radix digit converter: sequences load,
// division chunks, stack pushes and pops. Depends on rdc_pkg.
module rdc_ctrl
  import rdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (status.q_zero) begin
          state_nxt = ST_POP;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_POP: begin
        if (status.cnt_zero || (status.cnt_one && status.pop_ready)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_PUSH: begin
        cmd.push     = 1'b1;
        cmd.div_init = !status.q_zero;
      end
      ST_POP: begin
        cmd.pop = !status.cnt_zero && status.pop_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/rdc_checker.sv -----
// Port checker for the radix digit converter, bound to the top level.
// Depends on rdc_pkg and radix_digit_converter.
module rdc_checker
  import rdc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("in_tready high while converting");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("output item changed under stall");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_DATA_W-1:DIGIT_W] == '0))
    else $error("digit padding bits not zero");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
